// ===== hw/rtl/eg_pkg.sv =====
`timescale 1ns / 1ps

package eg_pkg;

    localparam int VALUE_W  = 16;
    localparam int WORD_W   = 31;
    localparam int LENGTH_W = 5;
    localparam int ZCOUNT_W = 4;
    localparam int MAG_W    = 15;

    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } t_command;

    typedef struct packed {
        logic [WORD_W-1:0]   code_word;
        logic [LENGTH_W-1:0] code_length;
        logic [VALUE_W-1:0]  decoded_value;
        logic                range_error;
    } t_eg_result;

    // Mirror a 16-bit value: bit i moves to bit 15-i.
    function automatic logic [VALUE_W-1:0] bit_rev16(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] r;
        for (int i = 0; i < VALUE_W; i++) begin
            r[VALUE_W-1-i] = v[i];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/eg_encode.sv =====
`timescale 1ns / 1ps

module eg_encode
    import eg_pkg::*;
(
    input  logic               i_signed_mode,
    input  logic [VALUE_W-1:0] i_value,
    output t_eg_result         o_result
);

    logic [VALUE_W-1:0]  neg_x;
    logic [VALUE_W-1:0]  mapped;
    logic                err;
    logic [LENGTH_W-1:0] nbits;
    logic [LENGTH_W:0]   len_wide;
    logic [LENGTH_W-1:0] len;
    logic [WORD_W-1:0]   aligned;

    assign neg_x = ~i_value + 16'd1;

    // Map the value to a positive code number in 1..65535.
    always_comb begin
        if (i_signed_mode) begin
            err = (i_value == 16'h8000);
            if (i_value[VALUE_W-1]) begin
                mapped = {neg_x[MAG_W-1:0], 1'b1};
            end else if (i_value == '0) begin
                mapped = 16'd1;
            end else begin
                mapped = {i_value[MAG_W-1:0], 1'b0};
            end
        end else begin
            err    = (i_value == 16'hFFFF);
            mapped = i_value + 16'd1;
        end
    end

    // Number of significant bits of the mapped value.
    always_comb begin
        nbits = '0;
        for (int i = 0; i < VALUE_W; i++) begin
            if (mapped[i]) begin
                nbits = LENGTH_W'(i + 1);
            end
        end
    end

    assign len_wide = {nbits, 1'b0} - 6'd1;
    assign len      = len_wide[LENGTH_W-1:0];

    // The mirrored value sits at the top of the word; shifting right by 31-L
    // leaves n-1 zeros below the leading one.
    assign aligned = {bit_rev16(mapped), 15'b0} >> (5'd31 - len);

    always_comb begin
        o_result.decoded_value = '0;
        o_result.range_error   = err;
        o_result.code_word     = err ? '0 : aligned;
        o_result.code_length   = err ? '0 : len;
    end

endmodule

// ===== hw/rtl/eg_decode.sv =====
`timescale 1ns / 1ps

module eg_decode
    import eg_pkg::*;
(
    input  logic              i_signed_mode,
    input  logic [WORD_W-1:0] i_word,
    output t_eg_result        o_result
);

    logic                err;
    logic [ZCOUNT_W-1:0] zeros;
    logic [WORD_W-1:0]   shifted;
    logic [VALUE_W-1:0]  mapped;
    logic [MAG_W-1:0]    mag;
    logic [VALUE_W-1:0]  value;

    // Sixteen or more trailing zeros, or no one at all, cannot be decoded.
    assign err = (i_word[VALUE_W-1:0] == '0);

    always_comb begin
        zeros = '0;
        for (int i = VALUE_W - 1; i >= 0; i--) begin
            if (i_word[i]) begin
                zeros = ZCOUNT_W'(i);
            end
        end
    end

    // Bring the leading one to bit 0, mirror, and drop the bits past the code.
    assign shifted = i_word >> zeros;
    assign mapped  = bit_rev16(shifted[VALUE_W-1:0]) >> (4'd15 - zeros);
    assign mag     = mapped[VALUE_W-1:1];

    always_comb begin
        if (i_signed_mode) begin
            if (mapped[0]) begin
                value = ~{1'b0, mag} + 16'd1;
            end else begin
                value = {1'b0, mag};
            end
        end else begin
            value = mapped - 16'd1;
        end
    end

    always_comb begin
        o_result.code_word     = '0;
        o_result.range_error   = err;
        o_result.code_length   = err ? '0 : {zeros, 1'b1};
        o_result.decoded_value = err ? '0 : value;
    end

endmodule

// ===== hw/rtl/exp_golomb_codec.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_ready  i_command, i_signed_mode, i_operand
// result    out        o_valid / i_ready  o_code_word, o_code_length,
//                                         o_decoded_value, o_range_error
//
// Every transfer on the input produces exactly one result, via the input and
// then the result register. A new item can be taken every cycle unless the
// result side stalls; each register advances whenever the stage after it is
// empty or drains. On a result-side stall the input register still holds one
// more item. Reset is synchronous and active low and empties both registers.

module exp_golomb_codec
    import eg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_command,
    input  logic                i_signed_mode,
    input  logic [31:0]         i_operand,

    output logic                o_valid,
    input  logic                i_ready,
    output logic [WORD_W-1:0]   o_code_word,
    output logic [LENGTH_W-1:0] o_code_length,
    output logic [VALUE_W-1:0]  o_decoded_value,
    output logic                o_range_error
);

    logic        r_in_valid;
    t_command    r_in_cmd;
    logic        r_in_sgn;
    logic [31:0] r_in_op;

    logic        r_out_valid;
    t_eg_result  r_out;

    t_eg_result  enc_result;
    t_eg_result  dec_result;
    t_eg_result  n_out;

    logic        adv_out;
    logic        adv_in;

    // The result register loads when it is empty or its item is taken; the
    // input register loads when it is empty or passes its item on.
    assign adv_out = !r_out_valid || i_ready;
    assign adv_in  = !r_in_valid || adv_out;
    assign o_ready = adv_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv_in) begin
                r_in_valid <= i_valid;
            end
            if (adv_out) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_in && i_valid) begin
            r_in_cmd <= t_command'(i_command);
            r_in_sgn <= i_signed_mode;
            r_in_op  <= i_operand;
        end
        if (adv_out && r_in_valid) begin
            r_out <= n_out;
        end
    end

    // Both directions are computed every cycle; the command picks one.
    // The encoder sees only the low half of the operand.
    eg_encode u_encode (
        .i_signed_mode (r_in_sgn),
        .i_value       (r_in_op[VALUE_W-1:0]),
        .o_result      (enc_result)
    );

    // Bit 31 of a code word can never fall inside a decodable code.
    eg_decode u_decode (
        .i_signed_mode (r_in_sgn),
        .i_word        (r_in_op[WORD_W-1:0]),
        .o_result      (dec_result)
    );

    always_comb begin
        unique case (r_in_cmd)
            CMD_ENCODE: n_out = enc_result;
            CMD_DECODE: n_out = dec_result;
            default:    n_out = enc_result;
        endcase
    end

    assign o_valid         = r_out_valid;
    assign o_code_word     = r_out.code_word;
    assign o_code_length   = r_out.code_length;
    assign o_decoded_value = r_out.decoded_value;
    assign o_range_error   = r_out.range_error;

    // A failed item carries nothing but its error flag.
    a_error_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_range_error) |->
        (o_code_word == '0 && o_code_length == '0 && o_decoded_value == '0))
        else $error("error result carries nonzero fields");

    // Every good code has an odd length.
    a_odd_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_range_error) |-> o_code_length[0])
        else $error("code length is not odd");

    // With the result register empty the input side can never be blocked.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with an empty result register");

    // An accepted item is held in the input register on the next cycle.
    a_item_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_in_valid)
        else $error("accepted item was lost");

endmodule
